// File: hdl/tpgjd_pkg.sv
// Package for the two priority group job dispatcher.
// Holds sizes, item types, codes and the sequencer state enum.
// No dependencies; every other file of the block uses it.
package tpgjd_pkg;

    localparam int QUEUE_DEPTH  = 256;
    localparam int NUM_COUNTERS = 16;
    localparam int MAX_GROUP    = 64;

    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int CNTR_W  = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int JOB_W   = 16;
    localparam int GSZ_W   = 7;
    localparam int CID_W   = 4;
    localparam int NUM_W   = JOB_W + 1;

    // Input function codes.
    localparam logic [1:0] FUNC_KICK  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_RSVD  = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_ACCEPT = 3'd0;
    localparam logic [2:0] ST_REJECT = 3'd1;
    localparam logic [2:0] ST_NONE   = 3'd2;
    localparam logic [2:0] ST_JOB    = 3'd3;
    localparam logic [2:0] ST_COUNT  = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic        high_priority;
        logic [15:0] num_jobs;
        logic [6:0]  group_size;
        logic [15:0] work_tag;
        logic [3:0]  counter_id;
        logic        use_counter;
        logic [5:0]  worker_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] job_id;
        logic [5:0]  id_in_group;
        logic [7:0]  group_index;
        logic [15:0] out_tag;
        logic [5:0]  out_worker;
        logic [15:0] counter_value;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_KICK,
        OP_POP,
        OP_QUERY
    } t_op;

    // Classified command handed from the front to the back.
    typedef struct packed {
        t_op         op;
        logic        hi;
        logic [15:0] jobs;
        logic [6:0]  gsz;
        logic [15:0] tag;
        logic [3:0]  cid;
        logic        has_cnt;
        logic [5:0]  worker;
    } t_cmd;

    // One queued group.
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] first;
        logic [6:0]  count;
        logic [7:0]  gidx;
        logic [3:0]  cid;
        logic        has_cnt;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_WRITE,
        S_CNT,
        S_POP_RD,
        S_EMIT,
        S_POP_CNT,
        S_RESP
    } t_state;

endpackage

// File: hdl/tpgjd_front.sv
// Front end of the dispatcher: accepts input items, classifies them and
// queues the resulting commands in a two entry FIFO. Uses tpgjd_pkg.
module tpgjd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tpgjd_pkg::t_in_item i_in_item,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output tpgjd_pkg::t_cmd     o_cmd
);

    tpgjd_pkg::t_cmd r_q [2];
    logic [1:0]      r_count;
    logic            r_wp;
    logic            r_rp;
    tpgjd_pkg::t_cmd cls;
    logic            push;
    logic            pop;
    logic            take;

    // Classify the item: decode the function, clamp the group size and qualify the counter.
    always_comb begin
        cls         = '0;
        cls.op      = tpgjd_pkg::OP_QUERY;
        if (i_in_item.func == tpgjd_pkg::FUNC_KICK) begin
            cls.op = tpgjd_pkg::OP_KICK;
        end else if (i_in_item.func == tpgjd_pkg::FUNC_POP) begin
            cls.op = tpgjd_pkg::OP_POP;
        end
        cls.hi      = i_in_item.high_priority;
        cls.jobs    = i_in_item.num_jobs;
        cls.gsz     = i_in_item.group_size;
        if (i_in_item.group_size == '0) begin
            cls.gsz = 7'd1;
        end else if (i_in_item.group_size > 7'(tpgjd_pkg::MAX_GROUP)) begin
            cls.gsz = 7'(tpgjd_pkg::MAX_GROUP);
        end
        cls.tag     = i_in_item.work_tag;
        cls.cid     = i_in_item.counter_id;
        cls.has_cnt = i_in_item.use_counter &&
                      ({1'b0, i_in_item.counter_id} < 5'(tpgjd_pkg::NUM_COUNTERS));
        cls.worker  = i_in_item.worker_id;
    end

    // Unused function codes are accepted and dropped.
    assign o_in_ready  = (r_count != 2'd2);
    assign take        = i_in_valid && o_in_ready;
    assign push        = take && (i_in_item.func != tpgjd_pkg::FUNC_RSVD);
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // FIFO pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    // FIFO storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

// File: hdl/tpgjd_div.sv
// Restoring divider, one quotient bit a cycle, for the group count.
// Uses tpgjd_pkg for widths.
module tpgjd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tpgjd_pkg::NUM_W-1:0]  i_num,
    input  logic [tpgjd_pkg::GSZ_W-1:0]  i_den,
    output logic                         o_done,
    output logic [tpgjd_pkg::JOB_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(tpgjd_pkg::NUM_W + 1);

    logic [tpgjd_pkg::NUM_W-1:0] r_quo;
    logic [tpgjd_pkg::GSZ_W:0]   r_rem;
    logic [tpgjd_pkg::GSZ_W-1:0] r_den;
    logic [STEP_W-1:0]           r_step;
    logic                        r_busy;
    logic                        r_done;
    logic [tpgjd_pkg::GSZ_W:0]   shifted;
    logic                        fits;

    assign shifted = {r_rem[tpgjd_pkg::GSZ_W-1:0], r_quo[tpgjd_pkg::NUM_W-1]};
    assign fits    = shifted >= {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_quo[tpgjd_pkg::JOB_W-1:0];

    // Control: count the steps and flag completion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(tpgjd_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one numerator bit and subtract when it fits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? (shifted - {1'b0, r_den}) : shifted;
            r_quo <= {r_quo[tpgjd_pkg::NUM_W-2:0], fits};
        end
    end

endmodule

// File: hdl/tpgjd_back.sv
// Back end of the dispatcher: the two group rings, completion counters
// and the sequencer that runs kicks, pops and queries. Uses tpgjd_pkg and
// tpgjd_div.
module tpgjd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  tpgjd_pkg::t_cmd      i_cmd,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tpgjd_pkg::t_out_item o_out_item
);

    tpgjd_pkg::t_state r_state;
    tpgjd_pkg::t_state n_state;

    tpgjd_pkg::t_entry r_mem_hi [tpgjd_pkg::QUEUE_DEPTH];
    tpgjd_pkg::t_entry r_mem_lo [tpgjd_pkg::QUEUE_DEPTH];
    tpgjd_pkg::t_entry r_rd_hi;
    tpgjd_pkg::t_entry r_rd_lo;
    logic [15:0]       r_cnt [tpgjd_pkg::NUM_COUNTERS];

    logic [tpgjd_pkg::PTR_W-1:0] r_wp_hi;
    logic [tpgjd_pkg::PTR_W-1:0] r_rp_hi;
    logic [tpgjd_pkg::PTR_W-1:0] r_wp_lo;
    logic [tpgjd_pkg::PTR_W-1:0] r_rp_lo;

    tpgjd_pkg::t_cmd   r_cmd;
    tpgjd_pkg::t_entry r_ent;
    logic              r_sel_hi;
    logic [15:0]       r_groups;
    logic [15:0]       r_i;
    logic [15:0]       r_first;
    logic [15:0]       r_left;
    logic [6:0]        r_j;
    logic [2:0]        r_status;
    logic [15:0]       r_cval;

    logic                  r_out_valid;
    tpgjd_pkg::t_out_item  r_out_item;

    logic                        can_load;
    logic                        div_start;
    logic                        div_done;
    logic [15:0]                 div_quot;
    logic [tpgjd_pkg::PTR_W-1:0] occ_hi;
    logic [tpgjd_pkg::PTR_W-1:0] occ_lo;
    logic [tpgjd_pkg::PTR_W-1:0] room;
    logic [3:0]                  cidx;
    logic                        cidx_ok;
    logic [15:0]                 cnt_rd;
    logic [16:0]                 cnt_sum;
    tpgjd_pkg::t_entry           wr_ent;
    logic [6:0]                  j_next;
    logic                        job_last;

    assign can_load = !r_out_valid || i_out_ready;
    assign occ_hi   = r_wp_hi - r_rp_hi;
    assign occ_lo   = r_wp_lo - r_rp_lo;
    assign room     = tpgjd_pkg::PTR_W'(tpgjd_pkg::QUEUE_DEPTH)
                      - (r_cmd.hi ? occ_hi : occ_lo);
    assign j_next   = r_j + 7'd1;
    assign job_last = (j_next == r_ent.count);

    // Single read point into the counter bank.
    always_comb begin
        if (r_state == tpgjd_pkg::S_POP_CNT) begin
            cidx = r_ent.cid;
        end else if (r_state == tpgjd_pkg::S_IDLE) begin
            cidx = i_cmd.cid;
        end else begin
            cidx = r_cmd.cid;
        end
        cidx_ok = {1'b0, cidx} < 5'(tpgjd_pkg::NUM_COUNTERS);
        cnt_rd  = cidx_ok ? r_cnt[cidx[tpgjd_pkg::CNTR_W-1:0]] : 16'd0;
        cnt_sum = {1'b0, cnt_rd} + {1'b0, r_groups};
    end

    // Entry written for the current group of a kick.
    always_comb begin
        wr_ent         = '0;
        wr_ent.tag     = r_cmd.tag;
        wr_ent.first   = r_first;
        wr_ent.count   = (r_left < {9'd0, r_cmd.gsz}) ? r_left[6:0] : r_cmd.gsz;
        wr_ent.gidx    = r_i[7:0];
        wr_ent.cid     = r_cmd.cid;
        wr_ent.has_cnt = r_cmd.has_cnt;
    end

    tpgjd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({1'b0, i_cmd.jobs} + {10'd0, i_cmd.gsz} - 17'd1),
        .i_den   (i_cmd.gsz),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Next state and handshakes of the sequencer.
    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            tpgjd_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        tpgjd_pkg::OP_KICK: begin
                            div_start = 1'b1;
                            n_state   = tpgjd_pkg::S_DIV;
                        end
                        tpgjd_pkg::OP_POP: begin
                            if (occ_hi != '0 || occ_lo != '0) begin
                                n_state = tpgjd_pkg::S_POP_RD;
                            end else begin
                                n_state = tpgjd_pkg::S_RESP;
                            end
                        end
                        default: n_state = tpgjd_pkg::S_RESP;
                    endcase
                end
            end
            tpgjd_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = tpgjd_pkg::S_CHECK;
                end
            end
            tpgjd_pkg::S_CHECK: begin
                if (r_groups > {7'd0, room}) begin
                    n_state = tpgjd_pkg::S_RESP;
                end else if (r_groups == '0) begin
                    n_state = tpgjd_pkg::S_RESP;
                end else begin
                    n_state = tpgjd_pkg::S_WRITE;
                end
            end
            tpgjd_pkg::S_WRITE: begin
                if (r_i + 16'd1 == r_groups) begin
                    n_state = tpgjd_pkg::S_CNT;
                end
            end
            tpgjd_pkg::S_CNT:    n_state = tpgjd_pkg::S_RESP;
            tpgjd_pkg::S_POP_RD: begin
                if ((r_sel_hi ? r_rd_hi.count : r_rd_lo.count) == '0) begin
                    n_state = tpgjd_pkg::S_POP_CNT;
                end else begin
                    n_state = tpgjd_pkg::S_EMIT;
                end
            end
            tpgjd_pkg::S_EMIT: begin
                if (can_load && job_last) begin
                    n_state = tpgjd_pkg::S_POP_CNT;
                end
            end
            tpgjd_pkg::S_POP_CNT: n_state = tpgjd_pkg::S_IDLE;
            tpgjd_pkg::S_RESP: begin
                if (can_load) begin
                    n_state = tpgjd_pkg::S_IDLE;
                end
            end
            default: n_state = tpgjd_pkg::S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpgjd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring pointers, counters and the output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp_hi     <= '0;
            r_rp_hi     <= '0;
            r_wp_lo     <= '0;
            r_rp_lo     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < tpgjd_pkg::NUM_COUNTERS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            // The output register fills while emitting or responding and
            // empties once its item is taken.
            if ((r_state inside {tpgjd_pkg::S_EMIT, tpgjd_pkg::S_RESP}) && can_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                tpgjd_pkg::S_IDLE: begin
                    if (i_cmd_valid && i_cmd.op == tpgjd_pkg::OP_POP) begin
                        if (occ_hi != '0) begin
                            r_rp_hi <= r_rp_hi + 1'b1;
                        end else if (occ_lo != '0) begin
                            r_rp_lo <= r_rp_lo + 1'b1;
                        end
                    end
                end
                tpgjd_pkg::S_WRITE: begin
                    if (r_cmd.hi) begin
                        r_wp_hi <= r_wp_hi + 1'b1;
                    end else begin
                        r_wp_lo <= r_wp_lo + 1'b1;
                    end
                end
                tpgjd_pkg::S_CNT: begin
                    if (r_cmd.has_cnt) begin
                        r_cnt[cidx[tpgjd_pkg::CNTR_W-1:0]] <=
                            cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
                    end
                end
                tpgjd_pkg::S_POP_CNT: begin
                    if (r_ent.has_cnt && cidx_ok && cnt_rd != '0) begin
                        r_cnt[cidx[tpgjd_pkg::CNTR_W-1:0]] <= cnt_rd - 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the sequencer and the output payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tpgjd_pkg::S_IDLE: begin
                r_cmd  <= i_cmd;
                r_cval <= cnt_rd;
                if (i_cmd.op == tpgjd_pkg::OP_POP) begin
                    r_sel_hi <= (occ_hi != '0);
                    r_status <= tpgjd_pkg::ST_NONE;
                end else begin
                    r_status <= tpgjd_pkg::ST_COUNT;
                end
            end
            tpgjd_pkg::S_DIV: begin
                r_groups <= div_quot;
                r_i      <= '0;
                r_first  <= '0;
                r_left   <= r_cmd.jobs;
            end
            tpgjd_pkg::S_CHECK: begin
                r_status <= (r_groups > {7'd0, room}) ? tpgjd_pkg::ST_REJECT
                                                      : tpgjd_pkg::ST_ACCEPT;
            end
            tpgjd_pkg::S_WRITE: begin
                r_i     <= r_i + 16'd1;
                r_first <= r_first + {9'd0, r_cmd.gsz};
                r_left  <= r_left - {9'd0, r_cmd.gsz};
            end
            tpgjd_pkg::S_POP_RD: begin
                r_ent <= r_sel_hi ? r_rd_hi : r_rd_lo;
                r_j   <= '0;
            end
            tpgjd_pkg::S_EMIT: begin
                if (can_load) begin
                    r_j        <= j_next;
                    r_out_item <= '{status:        tpgjd_pkg::ST_JOB,
                                    job_id:        r_ent.first + {9'd0, r_j},
                                    id_in_group:   r_j[5:0],
                                    group_index:   r_ent.gidx,
                                    out_tag:       r_ent.tag,
                                    out_worker:    r_cmd.worker,
                                    counter_value: 16'd0,
                                    last:          job_last};
                end
            end
            tpgjd_pkg::S_RESP: begin
                if (can_load) begin
                    r_out_item <= '{status:        r_status,
                                    job_id:        16'd0,
                                    id_in_group:   6'd0,
                                    group_index:   8'd0,
                                    out_tag:       16'd0,
                                    out_worker:    6'd0,
                                    counter_value: (r_status == tpgjd_pkg::ST_COUNT)
                                                   ? r_cval : 16'd0,
                                    last:          1'b1};
                end
            end
            default: ;
        endcase
    end

    // High priority ring: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == tpgjd_pkg::S_WRITE && r_cmd.hi) begin
            r_mem_hi[r_wp_hi[tpgjd_pkg::SLOT_W-1:0]] <= wr_ent;
        end
        r_rd_hi <= r_mem_hi[r_rp_hi[tpgjd_pkg::SLOT_W-1:0]];
    end

    // Low priority ring: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == tpgjd_pkg::S_WRITE && !r_cmd.hi) begin
            r_mem_lo[r_wp_lo[tpgjd_pkg::SLOT_W-1:0]] <= wr_ent;
        end
        r_rd_lo <= r_mem_lo[r_rp_lo[tpgjd_pkg::SLOT_W-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hdl/two_priority_group_job_dispatcher.sv
// Top level of the two priority group job dispatcher.
// Joins tpgjd_front and tpgjd_back; uses tpgjd_pkg for the item types.
//
//   Channel   Valid          Ready          Payload
//   input     i_in_valid     o_in_ready     i_in_item  (t_in_item)
//   result    o_out_valid    i_out_ready    o_out_item (t_out_item)
//
// A kick runs 17 divider steps for the group count, then one ring write
// per group. A pop issues the jobs of one group one by one through the
// output register; a query gives a single result.
// The front queues two items, so input is taken while the back works.
// Reset is synchronous, active low; either side may stall at any time.
module two_priority_group_job_dispatcher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tpgjd_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tpgjd_pkg::t_out_item o_out_item
);

    logic            cmd_valid;
    logic            cmd_ready;
    tpgjd_pkg::t_cmd cmd;

    // Front: accept and classify items.
    tpgjd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Back: run commands against the rings and counters.
    tpgjd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// File: hdl/tpgjd_checker.sv
// Port checker for the dispatcher, bound to the top level.
// Uses tpgjd_pkg for the item types and status codes.
module tpgjd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input tpgjd_pkg::t_out_item o_out_item
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Only known status codes appear.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= tpgjd_pkg::ST_COUNT)
        else $error("unknown status");

    // Every non-job result is the single result of its item.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != tpgjd_pkg::ST_JOB
        |-> o_out_item.last && o_out_item.job_id == '0)
        else $error("non-job result malformed");

endmodule

bind two_priority_group_job_dispatcher tpgjd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
